// File: hdl/bal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list package
// Shared widths, operation and status codes, and the result beat structure.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int DATA_W       = 32;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_INSERT     = 3'd4,
        KIND_ERASE      = 3'd5,
        KIND_REMOVE     = 3'd6,
        KIND_DUMP       = 3'd7
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef struct packed {
        logic                load;
        t_status             status;
        logic [COUNT_W-1:0]  count;
        logic [DATA_W-1:0]   element;
        logic                last;
    } t_res;

endpackage

// File: hdl/bal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list sequencer
// Decodes one operation; walks the store one entry per cycle for shifts,
// compaction and dumps (dumps stall on a busy output); hands out result beats.
// ----------------------------------------------------------------------------
module bal_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bal_pkg::KIND_W-1:0]  i_kind,
    input  logic [bal_pkg::POS_W-1:0]   i_position,
    input  logic [bal_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_out_free,
    output bal_pkg::t_res               o_res,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [bal_pkg::DATA_W-1:0]  o_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    input  logic [bal_pkg::DATA_W-1:0]  i_rdata
);

    import bal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((POS_W > CW) ? POS_W : CW) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_REMOVE,
        S_DUMP,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_slot, n_slot;
    logic [DATA_W-1:0] r_val, n_val;
    t_status           r_status, n_status;

    logic              full;
    logic              empty;
    logic [EW-1:0]     pos_ext;
    logic [EW-1:0]     cnt_ext;
    logic [AW-1:0]     cnt_last;
    logic [AW-1:0]     ins_slot;
    logic [AW-1:0]     ers_slot;
    logic              at_last;

    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign pos_ext  = EW'(i_position);
    assign cnt_ext  = EW'(r_count);
    assign cnt_last = AW'(r_count - CW'(1));
    assign at_last  = (r_addr == cnt_last);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_wr     = r_wr;
        n_addr   = r_addr;
        n_slot   = r_slot;
        n_val    = r_val;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_slot;
        o_wdata  = r_val;
        o_res    = '0;
        ins_slot = '0;
        ers_slot = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val    = i_value;
                    n_status = ST_OK;
                    n_state  = S_FIN;
                    unique case (t_kind'(i_kind))
                        KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT: begin
                            if (t_kind'(i_kind) == KIND_PUSH_BACK) begin
                                ins_slot = AW'(r_count);
                            end else if (t_kind'(i_kind) == KIND_INSERT) begin
                                ins_slot = AW'(pos_ext - EW'(1));
                            end
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (t_kind'(i_kind) == KIND_INSERT &&
                                         (pos_ext == '0 ||
                                          pos_ext > cnt_ext + EW'(1))) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_slot = ins_slot;
                                if (EW'(ins_slot) == cnt_ext) begin
                                    n_state = S_PUT;
                                end else begin
                                    n_addr  = cnt_last;
                                    n_state = S_SHIFT_UP;
                                end
                            end
                        end
                        KIND_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        KIND_POP_FRONT, KIND_ERASE: begin
                            if (t_kind'(i_kind) == KIND_ERASE) begin
                                ers_slot = AW'(pos_ext - EW'(1));
                            end
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (t_kind'(i_kind) == KIND_ERASE &&
                                         (pos_ext == '0 || pos_ext > cnt_ext)) begin
                                n_status = ST_BADPOS;
                            end else if (EW'(ers_slot) + EW'(1) == cnt_ext) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_addr  = AW'(ers_slot + AW'(1));
                                n_state = S_SHIFT_DN;
                            end
                        end
                        KIND_REMOVE: begin
                            if (!empty) begin
                                n_addr  = '0;
                                n_wr    = '0;
                                n_state = S_REMOVE;
                            end
                        end
                        KIND_DUMP: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_addr  = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                o_we    = 1'b1;
                o_waddr = AW'(r_addr + AW'(1));
                o_wdata = i_rdata;
                if (r_addr == r_slot) begin
                    n_state = S_PUT;
                end else begin
                    n_addr = AW'(r_addr - AW'(1));
                end
            end
            S_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_slot;
                o_wdata = r_val;
                n_count = r_count + CW'(1);
                n_state = S_FIN;
            end
            S_SHIFT_DN: begin
                o_we    = 1'b1;
                o_waddr = AW'(r_addr - AW'(1));
                o_wdata = i_rdata;
                if (at_last) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end else begin
                    n_addr = AW'(r_addr + AW'(1));
                end
            end
            S_REMOVE: begin
                if (i_rdata != r_val) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(r_wr);
                    o_wdata = i_rdata;
                    n_wr    = r_wr + CW'(1);
                end
                if (at_last) begin
                    n_count = n_wr;
                    n_state = S_FIN;
                end else begin
                    n_addr = AW'(r_addr + AW'(1));
                end
            end
            S_DUMP: begin
                if (i_out_free) begin
                    o_res.load    = 1'b1;
                    o_res.status  = ST_OK;
                    o_res.count   = COUNT_W'(r_count);
                    o_res.element = i_rdata;
                    o_res.last    = at_last;
                    if (at_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr = AW'(r_addr + AW'(1));
                    end
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_res.load    = 1'b1;
                    o_res.status  = r_status;
                    o_res.count   = COUNT_W'(r_count);
                    o_res.element = '0;
                    o_res.last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_wr     <= n_wr;
        r_slot   <= n_slot;
        r_val    <= n_val;
        r_status <= n_status;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_raddr    = n_addr;

endmodule

// File: hdl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list engine
// Ordered list of signed 32-bit elements in a fixed store with operations
// for push, pop, positional insert and erase, value removal and dump.
// ----------------------------------------------------------------------------
// The input channel takes one operation beat (kind, position, value) when
// i_in_valid and o_in_ready are both high; the output channel delivers
// result beats (status, count, element, last) under o_out_valid and
// i_out_ready. Every operation yields one beat with last set, except a dump
// of a non-empty list, which yields one beat per element, first to last.
// One operation is in flight at a time. Push back, pop back and all error
// cases move no stored element. Insert, push front, erase and pop front
// move one stored element per cycle through the single RAM write port.
// Value removal reads every held element once. A dump sends one element
// per cycle while the receiver takes them.
// Reset empties the list at once; no clearing pass is needed because only
// entries below the count are ever read. A stalled receiver holds the
// result register, and the sequencer waits for it before the next beat,
// while the list itself is already updated.
// ----------------------------------------------------------------------------
module bounded_array_list_engine #(
    parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bal_pkg::KIND_W-1:0]   i_kind,
    input  logic [bal_pkg::POS_W-1:0]    i_position,
    input  logic [bal_pkg::DATA_W-1:0]   i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bal_pkg::STATUS_W-1:0] o_status,
    output logic [bal_pkg::COUNT_W-1:0]  o_count,
    output logic [bal_pkg::DATA_W-1:0]   o_element,
    output logic                         o_last
);

    import bal_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    t_res              res;
    logic              out_free;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_count;
    logic [DATA_W-1:0]   r_element;
    logic                r_last;

    assign out_free = !r_out_valid || i_out_ready;

    bal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_value    (i_value),
        .i_out_free (out_free),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    bal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_status  <= res.status;
            r_count   <= res.count;
            r_element <= res.element;
            r_last    <= res.last;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_count     = r_count;
    assign o_element   = r_element;
    assign o_last      = r_last;

endmodule

// File: tb/bal_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list checker
// Watches both channels of the list engine, keeps its own copy of the list,
// works out the result beats of every accepted operation and compares each
// result beat, field by field, with the oldest beat still awaited.
// ----------------------------------------------------------------------------
module bal_list_checker #(
    parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [bal_pkg::KIND_W-1:0]   i_kind,
    input  logic [bal_pkg::POS_W-1:0]    i_position,
    input  logic [bal_pkg::DATA_W-1:0]   i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [bal_pkg::STATUS_W-1:0] i_status,
    input  logic [bal_pkg::COUNT_W-1:0]  i_count,
    input  logic [bal_pkg::DATA_W-1:0]   i_element,
    input  logic                         i_last,
    output int                           o_mismatches,
    output int                           o_outstanding
);

    import bal_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic [DATA_W-1:0]  element;
        logic               last;
    } t_beat;

    t_beat             awaited_beats[$];
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len;
    int                mismatch_total;

    task automatic await_beat(input t_status st, input logic [DATA_W-1:0] elem,
                              input logic is_last);
        t_beat b;
        b.status  = st;
        b.count   = COUNT_W'(list_len);
        b.element = elem;
        b.last    = is_last;
        awaited_beats.push_back(b);
    endtask

    task automatic open_slot(input int slot, input logic [DATA_W-1:0] v);
        for (int i = list_len; i > slot; i--) begin
            list_mem[i] = list_mem[i - 1];
        end
        list_mem[slot] = v;
        list_len++;
    endtask

    task automatic close_slot(input int slot);
        for (int i = slot; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
        end
        list_len--;
    endtask

    task automatic apply_list_op(input t_kind op, input int pos, input logic [DATA_W-1:0] v);
        int kept;
        case (op)
            KIND_PUSH_BACK, KIND_PUSH_FRONT, KIND_INSERT: begin
                if (list_len >= CAPACITY) begin
                    await_beat(ST_FULL, '0, 1'b1);
                end else if (op == KIND_INSERT && (pos == 0 || pos > list_len + 1)) begin
                    await_beat(ST_BADPOS, '0, 1'b1);
                end else begin
                    if (op == KIND_PUSH_BACK) begin
                        open_slot(list_len, v);
                    end else if (op == KIND_PUSH_FRONT) begin
                        open_slot(0, v);
                    end else begin
                        open_slot(pos - 1, v);
                    end
                    await_beat(ST_OK, '0, 1'b1);
                end
            end
            KIND_POP_BACK, KIND_POP_FRONT, KIND_ERASE: begin
                if (list_len == 0) begin
                    await_beat(ST_EMPTY, '0, 1'b1);
                end else if (op == KIND_ERASE && (pos == 0 || pos > list_len)) begin
                    await_beat(ST_BADPOS, '0, 1'b1);
                end else begin
                    if (op == KIND_POP_BACK) begin
                        list_len--;
                    end else if (op == KIND_POP_FRONT) begin
                        close_slot(0);
                    end else begin
                        close_slot(pos - 1);
                    end
                    await_beat(ST_OK, '0, 1'b1);
                end
            end
            KIND_REMOVE: begin
                kept = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] != v) begin
                        list_mem[kept] = list_mem[i];
                        kept++;
                    end
                end
                list_len = kept;
                await_beat(ST_OK, '0, 1'b1);
            end
            KIND_DUMP: begin
                if (list_len == 0) begin
                    await_beat(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        await_beat(ST_OK, list_mem[i], i == list_len - 1);
                    end
                end
            end
        endcase
    endtask

    task automatic log_mismatch(input string what, input t_beat want, input t_beat got);
        if (mismatch_total < 10) begin
            $display("%0t: %s: expected status %0d count %0d element %h last %b",
                     $time, what, want.status, want.count, want.element, want.last);
            $display("    got status %0d count %0d element %h last %b",
                     got.status, got.count, got.element, got.last);
        end
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        t_beat got;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.status  = t_status'(i_status);
                got.count   = i_count;
                got.element = i_element;
                got.last    = i_last;
                if (awaited_beats.size() == 0) begin
                    log_mismatch("unexpected result beat", '0, got);
                end else begin
                    want = awaited_beats.pop_front();
                    if (got.status !== want.status || got.count !== want.count ||
                        got.element !== want.element || got.last !== want.last) begin
                        log_mismatch("result beat mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_list_op(t_kind'(i_kind), int'(i_position), i_value);
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= awaited_beats.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list engine testbench
// Drives directed corner operations and then random phases that fill, drain
// and mix operations on the list, with random gaps on both channels and one
// long receiver stall; the checker beside the engine judges every result.
// ----------------------------------------------------------------------------
module tb;
    import bal_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_OPS  = 200;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   value;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [DATA_W-1:0]   element;
    logic                last;
    int                  mismatches;
    int                  outstanding;
    int                  cycle_count = 0;
    bit                  send_burst  = 1'b0;
    bit                  recv_burst  = 1'b0;

    bounded_array_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_kind     (kind),
        .i_position (position),
        .i_value    (value),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_status   (status),
        .o_count    (count),
        .o_element  (element),
        .o_last     (last)
    );

    bal_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_kind       (kind),
        .i_position   (position),
        .i_value      (value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_status     (status),
        .i_count      (count),
        .i_element    (element),
        .i_last       (last),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom();
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'hFFFF_FFFF;
            5:       return 32'h0000_0000;
            6:       return 32'h0000_0001;
            default: return 32'h5A5A_A5A5;
        endcase
    endfunction

    task automatic send_op(input t_kind op, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] v);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        position <= pos;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random_op(input bit noisy);
        t_kind            op;
        logic [POS_W-1:0] pos;
        op  = t_kind'($urandom_range(0, 7));
        pos = noisy ? POS_W'($urandom()) : POS_W'($urandom_range(0, CAPACITY + 1));
        send_op(op, pos, pick_value());
    endtask

    initial begin
        int gap;
        int taken;
        taken = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken == 60) begin
                gap = 300;
            end else begin
                gap = recv_burst ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
            if (taken % 40 == 0) begin
                recv_burst = !recv_burst;
            end
        end
    end

    initial begin
        int  random_sent;
        bit  first_phase;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        kind     <= KIND_PUSH_BACK;
        position <= '0;
        value    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(KIND_POP_BACK,   5'd0,  32'h0);
        send_op(KIND_POP_FRONT,  5'd0,  32'h0);
        send_op(KIND_ERASE,      5'd1,  32'h0);
        send_op(KIND_DUMP,       5'd0,  32'h0);
        send_op(KIND_REMOVE,     5'd0,  32'h0);
        send_op(KIND_INSERT,     5'd0,  32'h1111_1111);
        send_op(KIND_INSERT,     5'd2,  32'h2222_2222);
        send_op(KIND_INSERT,     5'd1,  32'h8000_0000);
        send_op(KIND_PUSH_BACK,  5'd0,  32'h7FFF_FFFF);
        send_op(KIND_PUSH_FRONT, 5'd31, 32'hFFFF_FFFF);
        send_op(KIND_INSERT,     5'd31, 32'h3333_3333);
        send_op(KIND_INSERT,     5'd4,  32'h0000_0000);
        send_op(KIND_ERASE,      5'd0,  32'h0);
        send_op(KIND_ERASE,      5'd5,  32'h0);
        send_op(KIND_ERASE,      5'd2,  32'h0);
        send_op(KIND_PUSH_BACK,  5'd0,  32'hFFFF_FFFF);
        send_op(KIND_DUMP,       5'd0,  32'h0);
        send_op(KIND_REMOVE,     5'd0,  32'hFFFF_FFFF);
        send_op(KIND_REMOVE,     5'd0,  32'h0000_3039);
        send_op(KIND_POP_FRONT,  5'd0,  32'h0);
        send_op(KIND_POP_BACK,   5'd0,  32'h0);

        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_OPS) begin
            send_burst = ($urandom_range(0, 3) == 0);
            case (first_phase ? 0 : $urandom_range(0, 3))
                0: begin
                    repeat (CAPACITY + 2) begin
                        send_op($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                                POS_W'($urandom()), pick_value());
                    end
                    send_op(KIND_INSERT, POS_W'($urandom_range(1, CAPACITY + 1)), pick_value());
                    send_op(KIND_DUMP, POS_W'($urandom()), pick_value());
                    random_sent += CAPACITY + 4;
                end
                1: begin
                    repeat (CAPACITY + 2) begin
                        case ($urandom_range(0, 2))
                            0: send_op(KIND_POP_BACK, POS_W'($urandom()), pick_value());
                            1: send_op(KIND_POP_FRONT, POS_W'($urandom()), pick_value());
                            default: send_op(KIND_ERASE, POS_W'($urandom_range(1, 4)),
                                             pick_value());
                        endcase
                    end
                    send_op(KIND_DUMP, POS_W'($urandom()), pick_value());
                    random_sent += CAPACITY + 3;
                end
                default: begin
                    repeat (20) send_random_op($urandom_range(0, 4) == 0);
                    random_sent += 20;
                end
            endcase
            first_phase = 1'b0;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/bal_pkg.sv
hdl/bal_ram.sv
hdl/bal_ctrl.sv
hdl/bounded_array_list_engine.sv
tb/bal_list_checker.sv
tb/tb.sv
